[sv/fefd_pkg.sv]
`default_nettype none

package fefd_pkg;

    // Framing bytes and the escape codes that follow the escape byte.
    localparam logic [7:0] FLAG_BYTE    = 8'h7E;
    localparam logic [7:0] ESC_BYTE     = 8'h7D;
    localparam logic [7:0] ESC_FOR_ESC  = 8'h01;
    localparam logic [7:0] ESC_FOR_FLAG = 8'h02;

    // Event codes carried on the result channel.
    localparam logic [1:0] EV_DATA     = 2'd0;
    localparam logic [1:0] EV_DONE     = 2'd1;
    localparam logic [1:0] EV_BAD_ESC  = 2'd2;
    localparam logic [1:0] EV_OVERFLOW = 2'd3;

    // Reset value of the frame size limit.
    localparam logic [15:0] MAX_FRAME_RESET = 16'd1024;

    // One queue entry: the results caused by one input byte. When esc_first
    // is set, a raw escape byte goes out as data ahead of the main result.
    typedef struct packed {
        logic        esc_first;
        logic [7:0]  byte_val;
        logic [1:0]  event_code;
        logic [15:0] length;
    } fefd_entry_t;

endpackage

`default_nettype wire

[sv/fefd_parser.sv]
`default_nettype none

module fefd_parser (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_accept,
    input  wire logic [7:0]          rx_byte,
    input  wire logic                cfg_write,
    input  wire logic [15:0]         cfg_value,
    output fefd_pkg::fefd_entry_t    push_entry,
    output logic                     push
);
    import fefd_pkg::*;

    logic        in_frame_reg, in_frame_next;
    logic        esc_reg, esc_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [15:0] max_reg;
    logic        room;

    // One more byte fits when the count plus one stays within the limit.
    assign room = ({1'b0, cnt_reg} + 17'd1) <= {1'b0, max_reg};

    // Classify the byte against the framing state and build its results.
    always_comb begin
        in_frame_next = in_frame_reg;
        esc_next      = esc_reg;
        cnt_next      = cnt_reg;
        push          = 1'b0;
        push_entry    = '0;
        if (in_accept) begin
            if (!in_frame_reg) begin
                if (rx_byte == FLAG_BYTE) begin
                    if (room) begin
                        in_frame_next = 1'b1;
                        esc_next      = 1'b0;
                        cnt_next      = 16'd1;
                    end else begin
                        push                  = 1'b1;
                        push_entry.event_code = EV_OVERFLOW;
                        cnt_next              = '0;
                    end
                end
            end else if (rx_byte == FLAG_BYTE) begin
                if (cnt_reg <= 16'd1 && !esc_reg) begin
                    // A flag right after the opening flag restarts the frame.
                    cnt_next = 16'd1;
                end else begin
                    push                 = 1'b1;
                    push_entry.esc_first = esc_reg;
                    if (room) begin
                        push_entry.event_code = EV_DONE;
                        push_entry.length     = cnt_reg + 16'd1;
                    end else begin
                        push_entry.event_code = EV_OVERFLOW;
                    end
                    in_frame_next = 1'b0;
                    esc_next      = 1'b0;
                    cnt_next      = '0;
                end
            end else if (esc_reg) begin
                esc_next = 1'b0;
                push     = 1'b1;
                if (rx_byte == ESC_FOR_ESC) begin
                    push_entry.byte_val = ESC_BYTE;
                end else if (rx_byte == ESC_FOR_FLAG) begin
                    push_entry.byte_val = FLAG_BYTE;
                end else begin
                    push_entry.event_code = EV_BAD_ESC;
                    in_frame_next         = 1'b0;
                    cnt_next              = '0;
                end
            end else if (!room) begin
                push                  = 1'b1;
                push_entry.event_code = EV_OVERFLOW;
                in_frame_next         = 1'b0;
                cnt_next              = '0;
            end else begin
                cnt_next = cnt_reg + 16'd1;
                if (rx_byte == ESC_BYTE) begin
                    esc_next = 1'b1;
                end else begin
                    push                = 1'b1;
                    push_entry.byte_val = rx_byte;
                end
            end
        end
    end

    // Framing state and the size limit register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            esc_reg      <= 1'b0;
            cnt_reg      <= '0;
            max_reg      <= MAX_FRAME_RESET;
        end else begin
            in_frame_reg <= in_frame_next;
            esc_reg      <= esc_next;
            cnt_reg      <= cnt_next;
            if (cfg_write) begin
                max_reg <= cfg_value;
            end
        end
    end

    // While hunting, no count and no pending escape are kept.
    a_hunt_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_frame_reg |-> (cnt_reg == 16'd0 && !esc_reg))
        else $error("hunting with frame state left over");

    // A dropped frame always sends the parser back to hunting.
    a_drop_hunts: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && (push_entry.event_code == EV_BAD_ESC ||
                  push_entry.event_code == EV_OVERFLOW)) |=> !in_frame_reg)
        else $error("frame kept after a drop");

    // A raw escape byte is only sent ahead of a closing result.
    a_esc_first: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && push_entry.esc_first) |->
            (push_entry.event_code == EV_DONE || push_entry.event_code == EV_OVERFLOW))
        else $error("raw escape byte without a frame close");

endmodule

`default_nettype wire

[sv/fefd_queue.sv]
`default_nettype none

module fefd_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire fefd_pkg::fefd_entry_t push_entry,
    input  wire logic                  pop,
    output fefd_pkg::fefd_entry_t      head,
    output logic                       empty,
    output logic                       full
);
    import fefd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fefd_entry_t      mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign head  = mem_reg[rd_ptr_reg];

    // Pointer wrap and occupancy.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

[sv/fefd_unpacker.sv]
`default_nettype none

module fefd_unpacker (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire fefd_pkg::fefd_entry_t head,
    input  wire logic                  empty,
    output logic                       pop,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [23:0]                m_tdata,   // out_byte[7:0], frame_length[23:8]
    output logic [1:0]                 m_tuser,   // event_res[1:0]
    output logic                       m_tlast
);
    import fefd_pkg::*;

    logic half_reg, half_next;
    logic esc_phase;

    // The raw escape byte of an entry goes out first, then the main result.
    assign esc_phase = head.esc_first && !half_reg;
    assign m_tvalid  = !empty;
    assign m_tlast   = !esc_phase;
    assign m_tuser   = esc_phase ? EV_DATA : head.event_code;
    assign m_tdata   = esc_phase ? {16'd0, ESC_BYTE} : {head.length, head.byte_val};
    assign pop       = m_tvalid && m_tready && !esc_phase;

    // Track whether the escape byte of the head entry has already been sent.
    always_comb begin
        half_next = half_reg;
        if (m_tvalid && m_tready) begin
            half_next = esc_phase;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_reg <= 1'b0;
        end else begin
            half_reg <= half_next;
        end
    end

endmodule

`default_nettype wire

[sv/flag_escape_frame_deframer.sv]
// Flag and escape frame deframer.
// s_ channel: one raw received byte per transaction on s_tdata[7:0].
// m_ channel: one result per transaction. m_tdata carries the decoded byte in
// [7:0] and the frame length, both flags counted, in [23:8]; m_tuser carries
// the event (data byte, frame complete, bad escape drop, overflow drop);
// m_tlast marks the final result caused by one input byte.
// cfg_ channel: writes the frame size limit in bytes; cfg_ready is always high.
// A parser classifies each byte in the cycle it is taken and queues its
// results; an output stage replays them onto the m_ channel.
// A result is registered in the queue and offered on m_ from there.
// Throughput: one byte per cycle while the queue has room; a byte closing a
// frame after a raw escape byte produces two results on the output.
// When the receiver stalls, the queue of QUEUE_DEPTH entries fills and s_tready
// falls; bytes that produce no result never take a queue entry.
// Reset empties the queue, returns to flag hunting and sets the limit to 1024.
`default_nettype none

module flag_escape_frame_deframer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // rx_byte[7:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,    // out_byte[7:0], frame_length[23:8]
    output logic [1:0]       m_tuser,    // event_res[1:0]
    output logic             m_tlast,    // last_of_run
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data    // max_frame_bytes[15:0]
);
    import fefd_pkg::*;

    fefd_entry_t push_entry;
    fefd_entry_t head;
    logic        push;
    logic        pop;
    logic        empty;
    logic        full;

    assign s_tready  = !full;
    assign cfg_ready = 1'b1;

    // Front end: framing state and result generation.
    fefd_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (s_tvalid && s_tready),
        .rx_byte    (s_tdata),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_value  (cfg_data),
        .push_entry (push_entry),
        .push       (push)
    );

    // Queue between parser and output stage.
    fefd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (empty),
        .full       (full)
    );

    // Back end: spreads each entry over one or two result transactions.
    fefd_unpacker u_unpacker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

[verif/flag_escape_frame_deframer_tb.sv]
`timescale 1ns / 100ps

module flag_escape_frame_deframer_tb;
    import fefd_pkg::*;

    // One result as seen on the m_ channel.
    typedef struct packed {
        logic [7:0]  data;
        logic [1:0]  ev;
        logic [15:0] len;
        logic        last;
    } deframe_res_t;

    // Directed rows either feed one byte or write the frame size limit.
    typedef enum logic {ROW_RX, ROW_LIMIT} row_kind_t;

    typedef struct packed {
        row_kind_t    kind;
        logic [15:0]  value;
        logic         pinned;
        deframe_res_t want;
    } directed_row_t;

    // Ways a random frame can end or be damaged.
    typedef enum logic [2:0] {
        FR_CLEAN, FR_RESTART, FR_ESC_CLOSE, FR_BAD_ESC, FR_UNCLOSED
    } frame_flaw_t;

    localparam int N_DIRECTED = 31;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    // Predictor state, mirrored from the block.
    logic        rx_in_frame    = 1'b0;
    logic        rx_esc_pending = 1'b0;
    logic [15:0] rx_count       = 16'd0;
    logic [15:0] frame_limit    = MAX_FRAME_RESET;

    deframe_res_t  deframed_q [$];
    directed_row_t directed_rows [N_DIRECTED];
    int            step_results;
    int            rx_sent   = 0;
    int            err_count = 0;
    bit            idle_en   = 1'b1;
    logic [2:0]    stall_left = 3'd0;

    flag_escape_frame_deframer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Free-running clock, 10 ns period.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        err_count++;
        if (err_count <= 50)
            $display("%0t ns: mismatch: %s", $time, what);
    endtask

    task automatic hunt_again;
        rx_in_frame    = 1'b0;
        rx_esc_pending = 1'b0;
        rx_count       = 16'd0;
    endtask

    // Works out the results one received byte causes and queues them.
    task automatic deframe_byte(input logic [7:0] b);
        deframe_res_t res [0:1];
        int           n;
        bit           room;
        n = 0;
        room = ({1'b0, rx_count} + 17'd1) <= {1'b0, frame_limit};
        if (!rx_in_frame) begin
            if (b == FLAG_BYTE) begin
                if (room) begin
                    rx_in_frame    = 1'b1;
                    rx_esc_pending = 1'b0;
                    rx_count       = 16'd1;
                end else begin
                    res[n] = '{8'h00, EV_OVERFLOW, 16'd0, 1'b0};
                    n++;
                    hunt_again();
                end
            end
        end else if (b == FLAG_BYTE) begin
            if (rx_count <= 16'd1 && !rx_esc_pending) begin
                // A flag right after the opening flag starts the frame over.
                rx_count = 16'd1;
            end else begin
                // A pending escape byte is kept raw ahead of the close.
                if (rx_esc_pending) begin
                    res[n] = '{ESC_BYTE, EV_DATA, 16'd0, 1'b0};
                    n++;
                end
                if (room)
                    res[n] = '{8'h00, EV_DONE, rx_count + 16'd1, 1'b0};
                else
                    res[n] = '{8'h00, EV_OVERFLOW, 16'd0, 1'b0};
                n++;
                hunt_again();
            end
        end else if (rx_esc_pending) begin
            rx_esc_pending = 1'b0;
            if (b == ESC_FOR_ESC) begin
                res[n] = '{ESC_BYTE, EV_DATA, 16'd0, 1'b0};
            end else if (b == ESC_FOR_FLAG) begin
                res[n] = '{FLAG_BYTE, EV_DATA, 16'd0, 1'b0};
            end else begin
                res[n] = '{8'h00, EV_BAD_ESC, 16'd0, 1'b0};
                hunt_again();
            end
            n++;
        end else if (!room) begin
            res[n] = '{8'h00, EV_OVERFLOW, 16'd0, 1'b0};
            n++;
            hunt_again();
        end else begin
            rx_count = rx_count + 16'd1;
            if (b == ESC_BYTE) begin
                rx_esc_pending = 1'b1;
            end else begin
                res[n] = '{b, EV_DATA, 16'd0, 1'b0};
                n++;
            end
        end
        if (n > 0)
            res[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++)
            deframed_q.push_back(res[i]);
        step_results = n;
    endtask

    // Offers one byte on the s_ channel, with an occasional gap first, and
    // predicts its results once the transaction completes.
    task automatic send_rx(input logic [7:0] b);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        rx_sent++;
        deframe_byte(b);
    endtask

    // Writes the size limit once every expected result has come out.
    task automatic write_limit(input logic [15:0] v);
        s_tvalid <= 1'b0;
        while (deframed_q.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        frame_limit = v;
    endtask

    // Sends one frame of len content bytes, escaping flag and escape values.
    task automatic send_frame(input int len, input frame_flaw_t flaw);
        logic [7:0] c;
        int         k;
        send_rx(FLAG_BYTE);
        if (flaw == FR_RESTART)
            for (k = $urandom_range(1, 3); k > 0; k--) send_rx(FLAG_BYTE);
        for (k = 0; k < len; k++) begin
            c = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 7) == 0)
                c = $urandom_range(0, 1) ? ESC_BYTE : FLAG_BYTE;
            if (c == FLAG_BYTE || c == ESC_BYTE) begin
                send_rx(ESC_BYTE);
                send_rx(c == ESC_BYTE ? ESC_FOR_ESC : ESC_FOR_FLAG);
            end else begin
                send_rx(c);
            end
        end
        case (flaw)
            FR_BAD_ESC: begin
                send_rx(ESC_BYTE);
                do c = 8'($urandom_range(0, 255));
                while (c == ESC_FOR_ESC || c == ESC_FOR_FLAG || c == FLAG_BYTE);
                send_rx(c);
            end
            FR_ESC_CLOSE: begin
                send_rx(ESC_BYTE);
                send_rx(FLAG_BYTE);
            end
            FR_UNCLOSED: ;
            default: send_rx(FLAG_BYTE);
        endcase
    endtask

    // One setting of the limit: mostly short frames, some damaged, with line
    // noise between them. The phase ends with no frame open past its flag.
    task automatic run_phase(input logic [15:0] limit, input int n_items,
                             input bit with_idle);
        int          start;
        int          len;
        int          k;
        frame_flaw_t flaw;
        write_limit(limit);
        idle_en = with_idle;
        start = rx_sent;
        while (rx_sent - start < n_items) begin
            if ($urandom_range(0, 3) == 0)
                for (k = $urandom_range(1, 3); k > 0; k--)
                    send_rx(8'($urandom_range(0, 255)));
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 48)
                                              : $urandom_range(0, 10);
            case ($urandom_range(0, 9))
                6:       flaw = FR_RESTART;
                7:       flaw = FR_ESC_CLOSE;
                8:       flaw = FR_BAD_ESC;
                9:       flaw = FR_UNCLOSED;
                default: flaw = FR_CLEAN;
            endcase
            send_frame(len, flaw);
        end
        if (rx_in_frame)
            send_rx(FLAG_BYTE);
    endtask

    function automatic directed_row_t rx_free(input logic [7:0] b);
        return '{ROW_RX, {8'h00, b}, 1'b0, '0};
    endfunction

    function automatic directed_row_t rx_pinned(input logic [7:0] b, input logic [1:0] ev,
                                                input logic [7:0] data,
                                                input logic [15:0] len);
        return '{ROW_RX, {8'h00, b}, 1'b1, '{data, ev, len, 1'b1}};
    endfunction

    function automatic directed_row_t limit_row(input logic [15:0] v);
        return '{ROW_LIMIT, v, 1'b0, '0};
    endfunction

    // Result checking and receiver stalls.
    always @(posedge aclk) begin : result_check
        deframe_res_t got;
        deframe_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[7:0], m_tuser, m_tdata[23:8], m_tlast};
            if (deframed_q.size() == 0) begin
                flag_mismatch($sformatf("result %h with nothing expected", got));
            end else begin
                want = deframed_q.pop_front();
                if (got.data !== want.data)
                    flag_mismatch($sformatf("out_byte %h, expected %h", got.data, want.data));
                if (got.ev !== want.ev)
                    flag_mismatch($sformatf("event %0d, expected %0d", got.ev, want.ev));
                if (got.len !== want.len)
                    flag_mismatch($sformatf("frame_length %0d, expected %0d",
                                            got.len, want.len));
                if (got.last !== want.last)
                    flag_mismatch($sformatf("tlast %b, expected %b", got.last, want.last));
            end
        end
        if (stall_left != 3'd0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 3'd1;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= 3'($urandom_range(0, 6));
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Main stimulus.
    initial begin : stimulus
        directed_rows = '{
            rx_free(8'h00),                                       // noise while hunting
            rx_free(ESC_BYTE),
            rx_free(FLAG_BYTE),                                   // open
            rx_free(FLAG_BYTE),                                   // restart
            rx_pinned(8'h00, EV_DATA, 8'h00, 16'd0),
            rx_pinned(8'hFF, EV_DATA, 8'hFF, 16'd0),
            rx_free(ESC_BYTE),
            rx_pinned(ESC_FOR_ESC, EV_DATA, ESC_BYTE, 16'd0),
            rx_free(ESC_BYTE),
            rx_pinned(ESC_FOR_FLAG, EV_DATA, FLAG_BYTE, 16'd0),
            rx_pinned(FLAG_BYTE, EV_DONE, 8'h00, 16'd6),
            rx_free(FLAG_BYTE),                                   // flag after escape
            rx_free(ESC_BYTE),
            rx_free(FLAG_BYTE),
            rx_free(FLAG_BYTE),                                   // bad escapes
            rx_free(ESC_BYTE),
            rx_pinned(8'h55, EV_BAD_ESC, 8'h00, 16'd0),
            rx_free(FLAG_BYTE),
            rx_free(ESC_BYTE),
            rx_pinned(ESC_BYTE, EV_BAD_ESC, 8'h00, 16'd0),
            limit_row(16'd3),                                     // smallest frame
            rx_free(FLAG_BYTE),
            rx_pinned(8'h41, EV_DATA, 8'h41, 16'd0),
            rx_pinned(FLAG_BYTE, EV_DONE, 8'h00, 16'd3),
            rx_free(FLAG_BYTE),
            rx_free(8'h41),
            rx_free(8'h42),
            rx_pinned(8'h43, EV_OVERFLOW, 8'h00, 16'd0),
            limit_row(16'd0),                                     // no room at all
            rx_pinned(FLAG_BYTE, EV_OVERFLOW, 8'h00, 16'd0),
            limit_row(MAX_FRAME_RESET)
        };

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'h00;
        cfg_valid <= 1'b0;
        cfg_data  <= 16'h0000;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows; pinned rows replace the prediction with a typed result.
        for (int i = 0; i < N_DIRECTED; i++) begin
            if (directed_rows[i].kind == ROW_LIMIT) begin
                write_limit(directed_rows[i].value);
            end else begin
                send_rx(directed_rows[i].value[7:0]);
                if (directed_rows[i].pinned) begin
                    repeat (step_results) void'(deframed_q.pop_back());
                    deframed_q.push_back(directed_rows[i].want);
                end
            end
        end

        // Random phases over several limits; the small limits reach the size edges.
        run_phase(MAX_FRAME_RESET, 200, 1'b1);
        run_phase(16'hFFFF, 150, 1'b1);
        run_phase(16'd3, 150, 1'b1);
        run_phase(16'($urandom_range(4, 24)), 200, 1'b1);
        run_phase(16'd2, 60, 1'b1);
        run_phase(16'd1, 40, 1'b0);
        run_phase(16'($urandom_range(3, 65535)), 150, 1'b1);
        run_phase(MAX_FRAME_RESET, 250, 1'b0);

        // Drain and let any stray result show up.
        s_tvalid <= 1'b0;
        while (deframed_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (err_count == 0) begin
            $display("flag_escape_frame_deframer test passed");
        end else begin
            $display("flag_escape_frame_deframer test failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #100_000_000;
        $display("flag_escape_frame_deframer test failed");
        $finish;
    end

endmodule
